/* hw/rtl/gregorian_date_validate_and_day_diff_core_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the date difference core
// Shared property forms, clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_VALIDATE_AND_DAY_DIFF_CORE_DEFINES_SVH
`define GREGORIAN_DATE_VALIDATE_AND_DAY_DIFF_CORE_DEFINES_SVH

// Same-cycle implication.
`define GDVDD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gdvdd same-cycle check failed");

// Next-cycle implication.
`define GDVDD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gdvdd next-cycle check failed");

`endif

/* hw/rtl/gdvdd_pkg.sv */
// ---------------------------------------------------------------------------
// gdvdd_pkg
// Types, constants and helper functions for the date difference core.
// ---------------------------------------------------------------------------
package gdvdd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int DNUM_W  = 22;
    localparam int DIFF_W  = 22;

    localparam logic [YEAR_W-1:0] YEAR_MAX   = 14'd9999;
    localparam logic [HOUR_W-1:0] HOUR_MAX   = 5'd23;
    localparam logic [MIN_W-1:0]  MINUTE_MAX = 6'd59;
    localparam logic [SEC_W-1:0]  SECOND_MAX = 6'd59;

    localparam logic [DNUM_W-1:0] DAYS_PER_YEAR = 22'd365;

    // floor(y / 100) = (y * 5243) >> 19, exact for every 14-bit y
    localparam int DIV100_SHIFT = 19;
    localparam logic [26:0] DIV100_MUL = 27'd5243;

    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MON_MAY = 4'd5;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MON_JUL = 4'd7;
    localparam logic [MONTH_W-1:0] MON_AUG = 4'd8;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MON_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

    // months counted from March: March is 0, January 10, February 11
    localparam logic [MONTH_W-1:0] MM_JAN = 4'd10;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    function automatic logic [7:0] div100(input logic [YEAR_W-1:0] y);
        logic [26:0] prod;
        prod = 27'(y) * DIV100_MUL;
        return prod[26:DIV100_SHIFT];
    endfunction

    // length of a month; zero for a month code that names no month
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        len = '0;
        case (m) inside
            MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: len = 5'd31;
            MON_APR, MON_JUN, MON_SEP, MON_NOV:                            len = 5'd30;
            MON_FEB: len = leap ? 5'd29 : 5'd28;
            default: len = '0;
        endcase
        return len;
    endfunction

    // days before the start of a March-based month: (306*mm + 5) / 10
    function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] mm);
        logic [8:0] off;
        off = '0;
        case (mm)
            4'd0:    off = 9'd0;
            4'd1:    off = 9'd31;
            4'd2:    off = 9'd61;
            4'd3:    off = 9'd92;
            4'd4:    off = 9'd122;
            4'd5:    off = 9'd153;
            4'd6:    off = 9'd184;
            4'd7:    off = 9'd214;
            4'd8:    off = 9'd245;
            4'd9:    off = 9'd275;
            4'd10:   off = 9'd306;
            4'd11:   off = 9'd337;
            default: off = '0;
        endcase
        return off;
    endfunction

endpackage

/* hw/rtl/gdvdd_date_check.sv */
// ---------------------------------------------------------------------------
// gdvdd_date_check
// Range check of one Gregorian date, with the leap-year rule.
// ---------------------------------------------------------------------------
module gdvdd_date_check (
    input  gdvdd_pkg::date_t date,
    output logic             ok
);

    logic [7:0] q100;
    logic       rem100_zero;
    logic       leap;
    logic [gdvdd_pkg::DAY_W-1:0] len;

    assign q100        = gdvdd_pkg::div100(date.year);
    assign rem100_zero = (date.year == 14'(14'(q100) * 14'd100));
    // divisible by 4 and not by 100, or by 400
    assign leap = ((date.year[1:0] == 2'b00) && !rem100_zero)
               || (rem100_zero && (q100[1:0] == 2'b00));
    assign len  = gdvdd_pkg::month_len(date.month, leap);

    assign ok = (date.year != '0) && (date.year <= gdvdd_pkg::YEAR_MAX)
             && (date.day != '0) && (date.day <= len);

endmodule

/* hw/rtl/gdvdd_day_number.sv */
// ---------------------------------------------------------------------------
// gdvdd_day_number
// March-based day number of a date; the value is defined for valid dates.
// ---------------------------------------------------------------------------
module gdvdd_day_number (
    input  gdvdd_pkg::date_t                 date,
    output logic [gdvdd_pkg::DNUM_W-1:0]     dnum
);

    logic [gdvdd_pkg::MONTH_W-1:0] mm;
    logic [gdvdd_pkg::YEAR_W-1:0]  yy;
    logic [7:0]                    q100;
    logic [gdvdd_pkg::DNUM_W-1:0]  year_days;

    // shift months so the year starts in March; Jan and Feb belong to last year
    assign mm = (date.month >= gdvdd_pkg::MON_MAR) ? 4'(date.month - gdvdd_pkg::MON_MAR)
                                                   : 4'(date.month + 4'd9);
    assign yy = (mm >= gdvdd_pkg::MM_JAN) ? 14'(date.year - 14'd1) : date.year;

    assign q100      = gdvdd_pkg::div100(yy);
    assign year_days = 22'(22'(yy) * gdvdd_pkg::DAYS_PER_YEAR);

    assign dnum = 22'(year_days
                      + 22'(yy >> 2)
                      - 22'(q100)
                      + 22'(q100 >> 2)
                      + 22'(gdvdd_pkg::month_offset(mm))
                      + 22'(date.day)
                      - 22'd1);

endmodule

/* hw/rtl/gregorian_date_validate_and_day_diff_core.sv */
// ---------------------------------------------------------------------------
// gregorian_date_validate_and_day_diff_core
// Gregorian date-time check and absolute day difference, streaming in/out.
// ---------------------------------------------------------------------------
// Takes one transfer per cycle carrying date-time A and date B, and returns
// one transfer per item: a valid flag and the absolute day difference (zero
// when any field is out of range). Three register stages (input, day numbers,
// result) pass each item along; throughput is one item per clock while the
// result side accepts, with the day-number stage (a constant multiply by 365
// and one by the reciprocal of 100, then a short add chain) as the longest
// path. Each stage holds its item only while the stage ahead is full and
// stalled, so backpressure on the result side fills the empty stages first
// and then holds off the input; no item is dropped.
`include "gregorian_date_validate_and_day_diff_core_defines.svh"

module gregorian_date_validate_and_day_diff_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // year_a[13:0], month_a[17:14], day_a[22:18], hour_a[27:23], minute_a[33:28],
    // second_a[39:34], year_b[53:40], month_b[57:54], day_b[62:58], zero[63]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // day_diff[21:0], zero[23:22]
    output logic [23:0] m_tdata,
    // valid_res[0]
    output logic        m_tuser
);

    // input stage
    logic        s1_valid_reg, s1_valid_next;
    logic [62:0] s1_data_reg;
    logic        s1_ready;

    // day number stage
    logic        s2_valid_reg, s2_valid_next;
    logic        s2_ok_reg, s2_ok_next;
    logic [gdvdd_pkg::DNUM_W-1:0] s2_na_reg, s2_na_next;
    logic [gdvdd_pkg::DNUM_W-1:0] s2_nb_reg, s2_nb_next;
    logic        s2_ready;

    // result stage
    logic        out_valid_reg, out_valid_next;
    logic        out_ok_reg;
    logic [gdvdd_pkg::DIFF_W-1:0] out_diff_reg, out_diff_next;
    logic        out_ready;

    gdvdd_pkg::date_t date_a, date_b;
    logic [gdvdd_pkg::HOUR_W-1:0] hour_a;
    logic [gdvdd_pkg::MIN_W-1:0]  minute_a;
    logic [gdvdd_pkg::SEC_W-1:0]  second_a;
    logic ok_a, ok_b, time_ok;

    // a stage takes a new item when empty or when its content moves on
    assign out_ready = !out_valid_reg || m_tready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_tready  = s1_ready;

    assign s1_valid_next  = s1_ready  ? s_tvalid     : s1_valid_reg;
    assign s2_valid_next  = s2_ready  ? s1_valid_reg : s2_valid_reg;
    assign out_valid_next = out_ready ? s2_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // unpack the held transfer
    assign date_a.year  = s1_data_reg[13:0];
    assign date_a.month = s1_data_reg[17:14];
    assign date_a.day   = s1_data_reg[22:18];
    assign hour_a       = s1_data_reg[27:23];
    assign minute_a     = s1_data_reg[33:28];
    assign second_a     = s1_data_reg[39:34];
    assign date_b.year  = s1_data_reg[53:40];
    assign date_b.month = s1_data_reg[57:54];
    assign date_b.day   = s1_data_reg[62:58];

    gdvdd_date_check u_check_a (
        .date (date_a),
        .ok   (ok_a)
    );

    gdvdd_date_check u_check_b (
        .date (date_b),
        .ok   (ok_b)
    );

    gdvdd_day_number u_dnum_a (
        .date (date_a),
        .dnum (s2_na_next)
    );

    gdvdd_day_number u_dnum_b (
        .date (date_b),
        .dnum (s2_nb_next)
    );

    assign time_ok = (hour_a <= gdvdd_pkg::HOUR_MAX)
                  && (minute_a <= gdvdd_pkg::MINUTE_MAX)
                  && (second_a <= gdvdd_pkg::SECOND_MAX);
    assign s2_ok_next = ok_a && ok_b && time_ok;

    // force the difference to zero for a rejected item
    always_comb
    begin
        out_diff_next = '0;
        if (s2_ok_reg)
        begin
            if (s2_na_reg >= s2_nb_reg)
            begin
                out_diff_next = s2_na_reg - s2_nb_reg;
            end
            else
            begin
                out_diff_next = s2_nb_reg - s2_na_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && s_tvalid)
        begin
            s1_data_reg <= s_tdata[62:0];
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_ok_reg <= s2_ok_next;
            s2_na_reg <= s2_na_next;
            s2_nb_reg <= s2_nb_next;
        end
        if (out_ready && s2_valid_reg)
        begin
            out_ok_reg   <= s2_ok_reg;
            out_diff_reg <= out_diff_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_diff_reg};
    assign m_tuser  = out_ok_reg;

    // input is held off only when every stage is full and the output stalls
    `GDVDD_ASSERT_NOW(a_stall_only_when_full, !s_tready,
                      s1_valid_reg && s2_valid_reg && out_valid_reg && !m_tready)
    // an item leaving the input stage lands in the day number stage
    `GDVDD_ASSERT_NEXT(a_s1_advances, s1_valid_reg && s2_ready, s2_valid_reg)
    // a rejected item carries a zero difference
    `GDVDD_ASSERT_NOW(a_invalid_zero, m_tvalid && !m_tuser, m_tdata == 24'd0)
    // valid dates in years 1 to 9999 stay within the span of the calendar
    `GDVDD_ASSERT_NOW(a_diff_range, m_tvalid, m_tdata <= 24'd3652059)

endmodule

/* sim/gdvdd_day_diff_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Date difference checker
// Calendar helpers shared by the testbench, and a passive checker that
// predicts valid_res and day_diff for every input transfer and compares
// them, in order, against the result transfers of the core.
// ---------------------------------------------------------------------------
package gdvdd_tb_pkg;

    import gdvdd_pkg::*;

    // Input transfer layout, first member in the top bits of s_tdata.
    typedef struct packed {
        logic               pad;
        logic [DAY_W-1:0]   day_b;
        logic [MONTH_W-1:0] month_b;
        logic [YEAR_W-1:0]  year_b;
        logic [SEC_W-1:0]   second_a;
        logic [MIN_W-1:0]   minute_a;
        logic [HOUR_W-1:0]  hour_a;
        logic [DAY_W-1:0]   day_a;
        logic [MONTH_W-1:0] month_a;
        logic [YEAR_W-1:0]  year_a;
    } stamp_pair_t;

    typedef struct packed {
        logic              valid;
        logic [DIFF_W-1:0] diff;
    } day_diff_t;

    function automatic bit is_leap_year(input int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    // zero for a month code that names no month
    function automatic int unsigned days_in_month(input int unsigned y,
                                                  input logic [MONTH_W-1:0] m);
        int unsigned len;
        len = 0;
        case (m)
            MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC:
                len = 31;
            MON_APR, MON_JUN, MON_SEP, MON_NOV:
                len = 30;
            MON_FEB:
                len = is_leap_year(y) ? 29 : 28;
            default:
                len = 0;
        endcase
        return len;
    endfunction

endpackage

module gdvdd_day_diff_checker
    import gdvdd_pkg::*;
    import gdvdd_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tuser,
    output int          error_count,
    output int          pending,
    output int          checked_count,
    output int          valid_count
);

    day_diff_t expected_q[$];
    day_diff_t want;
    int        errors;
    int        checked;
    int        valid_seen;

    assign error_count   = errors;
    assign checked_count = checked;
    assign valid_count   = valid_seen;

    initial begin
        errors     = 0;
        checked    = 0;
        valid_seen = 0;
    end

    function automatic bit date_is_valid(input logic [YEAR_W-1:0] y,
                                         input logic [MONTH_W-1:0] m,
                                         input logic [DAY_W-1:0] d);
        return y >= 1 && y <= YEAR_MAX && d >= 1 && d <= days_in_month(y, m);
    endfunction

    // day count from a year that starts in March, so Feb 29 falls last
    function automatic int march_day_number(input int y, input int m, input int d);
        int mm;
        int yy;
        mm = (m + 9) % 12;
        yy = y - mm / 10;
        return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (306 * mm + 5) / 10 + d - 1;
    endfunction

    function automatic day_diff_t predict_day_diff(input stamp_pair_t p);
        day_diff_t r;
        int        na;
        int        nb;
        r.valid = date_is_valid(p.year_a, p.month_a, p.day_a)
                  && date_is_valid(p.year_b, p.month_b, p.day_b)
                  && p.hour_a <= HOUR_MAX && p.minute_a <= MINUTE_MAX
                  && p.second_a <= SECOND_MAX;
        r.diff = '0;
        if (r.valid) begin
            na = march_day_number(p.year_a, p.month_a, p.day_a);
            nb = march_day_number(p.year_b, p.month_b, p.day_b);
            r.diff = DIFF_W'((na >= nb) ? na - nb : nb - na);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        errors++;
        $display("%0t ns: %s mismatch on result %0d: got %0d, expected %0d",
                 $time, what, checked, got, exp_val);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pending <= 0;
        end
        else begin
            if (s_tvalid && s_tready)
                expected_q.push_back(predict_day_diff(stamp_pair_t'(s_tdata)));
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unrequested result, day_diff", m_tdata[21:0], 0);
                end
                else begin
                    want = expected_q.pop_front();
                    if (m_tuser !== want.valid)
                        report_mismatch("valid_res", m_tuser, want.valid);
                    if (m_tdata[21:0] !== want.diff)
                        report_mismatch("day_diff", m_tdata[21:0], want.diff);
                    if (m_tdata[23:22] !== 2'b00)
                        report_mismatch("tdata pad", m_tdata[23:22], 0);
                    if (want.valid)
                        valid_seen++;
                end
                checked++;
            end
            pending <= expected_q.size();
        end
    end

endmodule

/* sim/gregorian_date_validate_and_day_diff_core_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// gregorian_date_validate_and_day_diff_core_tb
// Stimulus and verdict for the date validation and day difference core.
// ---------------------------------------------------------------------------
// Sends directed calendar corners (limits, leap rules, every kind of bad
// field), then random date pairs, mostly well-formed, some with one field
// broken and some pure noise. Both stream sides idle at random, with one
// stretch of full throughput and drain pauses. The checker does the
// prediction and comparison.
module gregorian_date_validate_and_day_diff_core_tb;

    import gdvdd_pkg::*;
    import gdvdd_tb_pkg::*;

    localparam int RANDOM_ITEMS = 1925;
    localparam int STALL_LIMIT  = 2000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        steady_flow;

    int error_count;
    int pending;
    int checked_count;
    int valid_count;
    int items_sent;
    int quiet_cycles;

    gregorian_date_validate_and_day_diff_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    gdvdd_day_diff_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .error_count   (error_count),
        .pending       (pending),
        .checked_count (checked_count),
        .valid_count   (valid_count)
    );

    initial begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        steady_flow = 1'b0;
    end

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // result side: stall at random, with a 14 percent chance, unless flow is steady
    always @(posedge clk) begin
        if (rst_n)
            m_tready <= steady_flow || ($urandom_range(0, 99) >= 14);
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial quiet_cycles = 0;

    function automatic stamp_pair_t make_pair(input int ya, input int ma, input int da,
                                              input int ha, input int mi, input int se,
                                              input int yb, input int mb, input int db);
        stamp_pair_t p;
        p.pad      = 1'b0;
        p.year_a   = YEAR_W'(ya);
        p.month_a  = MONTH_W'(ma);
        p.day_a    = DAY_W'(da);
        p.hour_a   = HOUR_W'(ha);
        p.minute_a = MIN_W'(mi);
        p.second_a = SEC_W'(se);
        p.year_b   = YEAR_W'(yb);
        p.month_b  = MONTH_W'(mb);
        p.day_b    = DAY_W'(db);
        return p;
    endfunction

    // bias toward the range ends, century years and leap candidates
    function automatic int pick_year();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 1) ? 9999 : 1;
            1:       return 100 * $urandom_range(1, 99);
            2:       return 4 * $urandom_range(1, 2499);
            default: return $urandom_range(1, 9999);
        endcase
    endfunction

    function automatic int pick_day(input int y, input int m);
        int len;
        len = days_in_month(y, MONTH_W'(m));
        return ($urandom_range(0, 3) == 0) ? len : $urandom_range(1, len);
    endfunction

    function automatic stamp_pair_t random_valid_pair();
        int ya;
        int ma;
        int yb;
        int mb;
        ya = pick_year();
        ma = $urandom_range(1, 12);
        yb = ($urandom_range(0, 3) == 0) ? ya : pick_year();
        mb = $urandom_range(1, 12);
        return make_pair(ya, ma, pick_day(ya, ma), $urandom_range(0, 23),
                         $urandom_range(0, 59), $urandom_range(0, 59),
                         yb, mb, pick_day(yb, mb));
    endfunction

    // break exactly one field of a well-formed pair
    function automatic stamp_pair_t break_one_field(input stamp_pair_t p);
        int len;
        case ($urandom_range(0, 9))
            0: p.year_a   = '0;
            1: p.year_b   = YEAR_W'($urandom_range(10000, 16383));
            2: p.month_a  = $urandom_range(0, 1) ? '0 : MONTH_W'($urandom_range(13, 15));
            3: p.month_b  = $urandom_range(0, 1) ? '0 : MONTH_W'($urandom_range(13, 15));
            4: begin
                len = days_in_month(p.year_a, p.month_a);
                p.day_a = (len == 31 || $urandom_range(0, 1)) ? '0
                          : DAY_W'($urandom_range(len + 1, 31));
            end
            5: begin
                len = days_in_month(p.year_b, p.month_b);
                p.day_b = (len == 31 || $urandom_range(0, 1)) ? '0
                          : DAY_W'($urandom_range(len + 1, 31));
            end
            6: p.hour_a   = HOUR_W'($urandom_range(24, 31));
            7: p.minute_a = MIN_W'($urandom_range(60, 63));
            8: p.second_a = SEC_W'($urandom_range(60, 63));
            default: p.year_a = YEAR_W'($urandom_range(10000, 16383));
        endcase
        return p;
    endfunction

    function automatic stamp_pair_t noise_pair();
        return make_pair($urandom_range(0, 9999), $urandom_range(0, 15),
                         $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 9999), $urandom_range(0, 15),
                         $urandom_range(0, 31));
    endfunction

    task automatic send_pair(input stamp_pair_t p);
        if (!steady_flow && $urandom_range(0, 99) < 7) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
    endtask

    // hold input off until every outstanding result has been transferred
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        int r;
        items_sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // range limits, zero difference and full span both ways
        send_pair(make_pair(1, MON_JAN, 1, 0, 0, 0, 1, MON_JAN, 1));
        send_pair(make_pair(9999, MON_DEC, 31, 23, 59, 59, 1, MON_JAN, 1));
        send_pair(make_pair(1, MON_JAN, 1, 0, 0, 0, 9999, MON_DEC, 31));
        // leap rule: by 400, by 100, by 4, plain year
        send_pair(make_pair(2000, MON_FEB, 29, 12, 30, 30, 2000, MON_MAR, 1));
        send_pair(make_pair(1900, MON_FEB, 29, 12, 0, 0, 1900, MON_MAR, 1));
        send_pair(make_pair(2004, MON_FEB, 29, 1, 2, 3, 2001, MON_FEB, 28));
        send_pair(make_pair(2001, MON_FEB, 28, 1, 2, 3, 2001, MON_FEB, 29));
        send_pair(make_pair(2024, MON_FEB, 28, 0, 0, 0, 2024, MON_MAR, 1));
        send_pair(make_pair(2023, MON_DEC, 31, 0, 0, 0, 2024, MON_JAN, 1));
        send_pair(make_pair(1600, MON_FEB, 29, 23, 59, 59, 2400, MON_FEB, 29));
        // bad years
        send_pair(make_pair(0, MON_JAN, 1, 0, 0, 0, 1, MON_JAN, 1));
        send_pair(make_pair(1, MON_JAN, 1, 0, 0, 0, 0, MON_JAN, 1));
        send_pair(make_pair(10000, MON_JAN, 1, 0, 0, 0, 1, MON_JAN, 1));
        send_pair(make_pair(1, MON_JAN, 1, 0, 0, 0, 16383, MON_DEC, 31));
        // bad months
        send_pair(make_pair(2020, 0, 1, 0, 0, 0, 2020, MON_JAN, 1));
        send_pair(make_pair(2020, MON_JAN, 1, 0, 0, 0, 2020, 13, 1));
        send_pair(make_pair(2020, 15, 31, 0, 0, 0, 2020, 15, 31));
        // bad days
        send_pair(make_pair(2020, MON_MAY, 0, 0, 0, 0, 2020, MON_MAY, 1));
        send_pair(make_pair(2020, MON_MAY, 1, 0, 0, 0, 2020, MON_MAY, 0));
        send_pair(make_pair(2020, MON_APR, 31, 0, 0, 0, 2020, MON_JAN, 31));
        send_pair(make_pair(2020, MON_JAN, 31, 0, 0, 0, 2020, MON_NOV, 31));
        // bad time of A
        send_pair(make_pair(2020, MON_JUN, 15, 24, 0, 0, 2021, MON_JUN, 15));
        send_pair(make_pair(2020, MON_JUN, 15, 31, 63, 63, 2021, MON_JUN, 15));
        send_pair(make_pair(2020, MON_JUN, 15, 0, 60, 0, 2021, MON_JUN, 15));
        send_pair(make_pair(2020, MON_JUN, 15, 0, 0, 60, 2021, MON_JUN, 15));
        drain_results();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 650)
                steady_flow <= 1'b1;
            if (i == 1000)
                steady_flow <= 1'b0;
            if (i == 1400)
                drain_results();
            r = $urandom_range(0, 99);
            if (r < 70)
                send_pair(random_valid_pair());
            else if (r < 88)
                send_pair(break_one_field(random_valid_pair()));
            else
                send_pair(noise_pair());
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d date pairs (directed limits, leap rules, bad fields, random mix)",
                 items_sent);
        $display("Checked %0d results: %0d valid, %0d rejected",
                 checked_count, valid_count, checked_count - valid_count);
        if (error_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* gregorian_date_validate_and_day_diff_core.f */
+incdir+hw/rtl
hw/rtl/gdvdd_pkg.sv
hw/rtl/gdvdd_date_check.sv
hw/rtl/gdvdd_day_number.sv
hw/rtl/gregorian_date_validate_and_day_diff_core.sv
sim/gdvdd_day_diff_checker.sv
sim/gregorian_date_validate_and_day_diff_core_tb.sv
